[rtl/pks_pkg.sv]
// Shared types and constants for the packed key sorter.
// Used by pks_cell, pks_chain and packed_key_sorter_unit; depends on nothing.
package pks_pkg;

	localparam int KEY_W   = 16;
	localparam int IDENT_W = 16;
	localparam int ENTRY_W = KEY_W + IDENT_W;

	// Word index of the direction register on the configuration port.
	localparam logic REG_SORT_DESCENDING = 1'b0;

	// One stored entry: key in the low half, ident in the high half.
	typedef struct packed {
		logic [IDENT_W-1:0] ident;
		logic [KEY_W-1:0]   key;
	} pks_entry_t;

	// Control that every cell of a chain sees in the same cycle.
	typedef struct packed {
		logic ins;    // place the offered entry in its sorted slot
		logic shift;  // move every entry one cell toward the head
	} pks_ctrl_t;

	typedef enum logic {
		ST_LOAD,
		ST_DRAIN
	} pks_state_t;

endpackage

[rtl/pks_cell.sv]
// One slot of the insertion chain: holds a single entry and its valid bit.
// Depends on pks_pkg for the entry and control types.
module pks_cell
	import pks_pkg::*;
#(
	parameter bit DESCENDING = 1'b0
) (
	input  logic       clk,
	input  logic       arst_n,
	input  pks_ctrl_t  ctrl,
	input  pks_entry_t new_entry,
	input  logic       left_valid,
	input  logic       left_take,
	input  pks_entry_t left_data,
	input  logic       right_valid,
	input  pks_entry_t right_data,
	output logic       take,
	output logic       valid,
	output pks_entry_t data
);

	logic       valid_q;
	pks_entry_t data_q;
	logic       goes_ahead;

	// The new entry goes ahead of this one only on a strict key order, which keeps
	// equal keys in arrival order. An empty cell fills only when its left neighbor
	// holds an entry, so the occupied cells always form one run from the head.
	always_comb begin
		if (DESCENDING) begin
			goes_ahead = new_entry.key > data_q.key;
		end else begin
			goes_ahead = new_entry.key < data_q.key;
		end
		take = ctrl.ins && (valid_q ? goes_ahead : left_valid);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ctrl.shift) begin
			valid_q <= right_valid;
		end else if (take) begin
			valid_q <= 1'b1;
		end
	end

	// On insert, a cell either takes the new entry or the entry pushed out of its
	// left neighbor; on drain it takes the entry of its right neighbor.
	always_ff @(posedge clk) begin
		if (ctrl.shift) begin
			data_q <= right_data;
		end else if (take) begin
			data_q <= left_take ? left_data : new_entry;
		end
	end

	assign valid = valid_q;
	assign data  = data_q;

endmodule

[rtl/pks_chain.sv]
// A row of insertion cells that keeps its entries sorted in one direction.
// Depends on pks_pkg and pks_cell.
module pks_chain
	import pks_pkg::*;
#(
	parameter int DEPTH      = 64,
	parameter bit DESCENDING = 1'b0
) (
	input  logic       clk,
	input  logic       arst_n,
	input  pks_ctrl_t  ctrl,
	input  pks_entry_t new_entry,
	output pks_entry_t head
);

	logic       take  [DEPTH];
	logic       valid [DEPTH];
	pks_entry_t data  [DEPTH];

	// Cell 0 is the head and always counts as having a full left neighbor;
	// the neighbor of the last cell is an empty slot.
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic       lv;
		logic       lt;
		pks_entry_t ld;
		logic       rv;
		pks_entry_t rd;

		if (i == 0) begin : g_first
			assign lv = 1'b1;
			assign lt = 1'b0;
			assign ld = new_entry;
		end else begin : g_mid
			assign lv = valid[i-1];
			assign lt = take[i-1];
			assign ld = data[i-1];
		end

		if (i == DEPTH - 1) begin : g_last
			assign rv = 1'b0;
			assign rd = '0;
		end else begin : g_inner
			assign rv = valid[i+1];
			assign rd = data[i+1];
		end

		pks_cell #(
			.DESCENDING(DESCENDING)
		) u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctrl       (ctrl),
			.new_entry  (new_entry),
			.left_valid (lv),
			.left_take  (lt),
			.left_data  (ld),
			.right_valid(rv),
			.right_data (rd),
			.take       (take[i]),
			.valid      (valid[i]),
			.data       (data[i])
		);
	end

	assign head = data[0];

endmodule

[rtl/packed_key_sorter_unit.sv]
// Top level of the packed key sorter: handshakes, count, direction register.
// Depends on pks_pkg and pks_chain (two chains, one per sort direction).
//
//   channel | dir | tdata (low bit up)     | tlast     | tuser
//   s_*     | in  | key, ident             | last_item | -
//   m_*     | out | out_key, out_ident     | last_out  | overflow
//   apb     | in  | bit 0 of word 0: sort_descending
//
// While loading, s_tready is high; an entry drops into its sorted slot of the
// chains in the cycle it is accepted, or is dropped and sets m_tuser when full.
// After the last entry, with s_tready low, the set drains from the chain heads
// at one result per cycle while m_tready is high; a stall holds the head result.
// Reset empties both chains at once and sets ascending order.
module packed_key_sorter_unit
	import pks_pkg::*;
#(
	parameter int MAX_ITEMS = 64
) (
	input  logic                clk,
	input  logic                arst_n,
	// key, ident
	input  logic                s_tvalid,
	output logic                s_tready,
	input  logic [ENTRY_W-1:0]  s_tdata,
	input  logic                s_tlast,
	// out_key, out_ident
	output logic                m_tvalid,
	input  logic                m_tready,
	output logic [ENTRY_W-1:0]  m_tdata,
	output logic                m_tlast,
	// overflow
	output logic                m_tuser,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [2:0]          paddr,
	input  logic [31:0]         pwdata,
	output logic [31:0]         prdata,
	output logic                pready
);

	localparam int CNT_W = $clog2(MAX_ITEMS + 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(MAX_ITEMS);
	localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);

	pks_state_t       state_q, state_d;
	logic [CNT_W-1:0] count_q;
	logic             dropped_q;
	logic             sort_desc_q;
	logic             desc_set_q;

	logic       in_beat;
	logic       out_beat;
	logic       full;
	pks_ctrl_t  ctrl;
	pks_entry_t new_entry;
	pks_entry_t head_asc;
	pks_entry_t head_desc;

	assign in_beat   = s_tvalid && s_tready;
	assign out_beat  = m_tvalid && m_tready;
	assign full      = count_q == CNT_FULL;
	assign new_entry = pks_entry_t'(s_tdata);

	// Configuration port: single direction register, no wait states.
	assign pready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sort_desc_q <= 1'b0;
		end else if (psel && penable && pwrite && pready && paddr[2] == REG_SORT_DESCENDING) begin
			sort_desc_q <= pwdata[0];
		end
	end
	assign prdata = (paddr[2] == REG_SORT_DESCENDING) ? {31'b0, sort_desc_q} : 32'b0;

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_LOAD: begin
				if (in_beat && s_tlast) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				if (out_beat && count_q == CNT_ONE) begin
					state_d = ST_LOAD;
				end
			end
			default: state_d = ST_LOAD;
		endcase
	end

	// Outputs of the state machine.
	always_comb begin
		s_tready   = 1'b0;
		m_tvalid   = 1'b0;
		unique case (state_q)
			ST_LOAD:  s_tready = 1'b1;
			ST_DRAIN: m_tvalid = 1'b1;
			default: begin
				s_tready = 1'b0;
				m_tvalid = 1'b0;
			end
		endcase
	end

	always_comb begin
		ctrl.ins   = in_beat && !full;
		ctrl.shift = out_beat;
	end

	// Entry count, drop flag and the direction frozen at the last entry.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_LOAD;
			count_q    <= '0;
			dropped_q  <= 1'b0;
			desc_set_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (ctrl.ins) begin
				count_q <= count_q + CNT_ONE;
			end else if (ctrl.shift) begin
				count_q <= count_q - CNT_ONE;
			end
			if (in_beat && full) begin
				dropped_q <= 1'b1;
			end else if (out_beat && count_q == CNT_ONE) begin
				dropped_q <= 1'b0;
			end
			if (in_beat && s_tlast) begin
				desc_set_q <= sort_desc_q;
			end
		end
	end

	// Both chains see every entry, so the direction may change up to the last one.
	pks_chain #(
		.DEPTH     (MAX_ITEMS),
		.DESCENDING(1'b0)
	) u_chain_asc (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctrl     (ctrl),
		.new_entry(new_entry),
		.head     (head_asc)
	);

	pks_chain #(
		.DEPTH     (MAX_ITEMS),
		.DESCENDING(1'b1)
	) u_chain_desc (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctrl     (ctrl),
		.new_entry(new_entry),
		.head     (head_desc)
	);

	assign m_tdata = desc_set_q ? head_desc : head_asc;
	assign m_tlast = count_q == CNT_ONE;
	assign m_tuser = dropped_q;

endmodule
